// ===== rtl/cpg_pkg.sv =====
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants for the midpoint circle point generator.
// ----------------------------------------------------------------------------
package cpg_pkg;

	localparam int CENTER_W  = 12;
	localparam int RADIUS_W  = 11;
	localparam int STEP_W    = 11;
	localparam int DEC_W     = 16;
	localparam int PIX_W     = 14;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_DATA_W = 32;
	localparam int IN_DATA_W  = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd2;

	localparam logic [2:0] PIX_LAST_IDX = 3'd7;

	typedef struct packed {
		logic [STEP_W-1:0] x;
		logic [STEP_W-1:0] y;
		logic              done;
	} step_t;

endpackage

// ===== rtl/cpg_front.sv =====
// ----------------------------------------------------------------------------
// cpg_front
// Accepts step requests, runs the decision update and queues step records.
// ----------------------------------------------------------------------------
module cpg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_start,
	output logic                          in_ready,
	input  logic [cpg_pkg::RADIUS_W-1:0]  radius,
	input  logic                          q_full,
	output logic                          push,
	output cpg_pkg::step_t                push_data
);

	logic [cpg_pkg::STEP_W-1:0] step_x_q;
	logic [cpg_pkg::STEP_W-1:0] step_y_q;
	logic [cpg_pkg::DEC_W-1:0]  decision_q;
	logic                       active_q;

	logic                       accept;
	logic                       run;
	logic [cpg_pkg::STEP_W-1:0] base_x;
	logic [cpg_pkg::STEP_W-1:0] base_y;
	logic [cpg_pkg::DEC_W-1:0]  base_d;
	logic                       d_neg;
	logic [cpg_pkg::STEP_W:0]   nx;
	logic [cpg_pkg::STEP_W-1:0] ny;
	logic [cpg_pkg::DEC_W-1:0]  x4;
	logic [cpg_pkg::DEC_W-1:0]  y4;
	logic [cpg_pkg::DEC_W-1:0]  next_d;
	logic                       done;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign run      = in_start || active_q;

	always_comb begin
		base_x = in_start ? '0 : step_x_q;
		base_y = in_start ? radius : step_y_q;
		base_d = in_start ? (16'd3 - {4'b0, radius, 1'b0}) : decision_q;
		d_neg  = base_d[cpg_pkg::DEC_W-1];
		x4     = {3'b0, base_x, 2'b0};
		y4     = {3'b0, base_y, 2'b0};
		if (d_neg) begin
			next_d = base_d + x4 + 16'd6;
			ny     = base_y;
		end else begin
			next_d = base_d + x4 - y4 + 16'd10;
			ny     = (base_y != '0) ? base_y - 11'd1 : '0;
		end
		nx   = {1'b0, base_x} + 12'd1;
		done = nx > {1'b0, ny};
	end

	assign push           = accept && run;
	assign push_data.x    = base_x;
	assign push_data.y    = base_y;
	assign push_data.done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q   <= '0;
			step_y_q   <= '0;
			decision_q <= '0;
			active_q   <= 1'b0;
		end else if (push) begin
			step_x_q   <= nx[cpg_pkg::STEP_W-1:0];
			step_y_q   <= ny;
			decision_q <= next_d;
			active_q   <= !done;
		end
	end

`ifndef SYNTHESIS
	a_done_ends_circle: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_data.done |=> !active_q)
		else $error("circle still active after final step");
	a_idle_advance_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		!in_start && !active_q |-> !push)
		else $error("step queued without a circle in progress");
`endif

endmodule

// ===== rtl/cpg_queue.sv =====
// ----------------------------------------------------------------------------
// cpg_queue
// Short step-record queue between the front and the pixel emitter.
// ----------------------------------------------------------------------------
module cpg_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cpg_pkg::step_t  push_data,
	input  logic            pop,
	output cpg_pkg::step_t  pop_data,
	output logic            full,
	output logic            empty
);

	cpg_pkg::step_t                  mem_q [cpg_pkg::QUEUE_DEPTH];
	logic [cpg_pkg::QUEUE_AW-1:0]    wr_ptr_q;
	logic [cpg_pkg::QUEUE_AW-1:0]    rd_ptr_q;
	logic [cpg_pkg::QUEUE_CW-1:0]    count_q;

	assign full     = count_q == cpg_pkg::QUEUE_CW'(cpg_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full step queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty step queue");
`endif

endmodule

// ===== rtl/cpg_back.sv =====
// ----------------------------------------------------------------------------
// cpg_back
// Expands each step record into eight symmetric pixels, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module cpg_back #(
	parameter int COORD_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  cpg_pkg::step_t                      q_data,
	output logic                                pop,
	input  logic [cpg_pkg::CENTER_W-1:0]        center_col,
	input  logic [cpg_pkg::CENTER_W-1:0]        center_row,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cpg_pkg::PIX_W-1:0]           out_col,
	output logic [cpg_pkg::PIX_W-1:0]           out_row,
	output logic                                out_last,
	output logic                                out_done
);

	localparam int MASK_BITS = (COORD_BITS < cpg_pkg::CENTER_W) ?
		COORD_BITS : cpg_pkg::CENTER_W;
	localparam logic [cpg_pkg::CENTER_W-1:0] CMASK =
		cpg_pkg::CENTER_W'((1 << MASK_BITS) - 1);

	cpg_pkg::step_t              cur_q;
	logic                        have_q;
	logic [2:0]                  idx_q;
	logic                        valid_q;
	logic [cpg_pkg::PIX_W-1:0]   col_q;
	logic [cpg_pkg::PIX_W-1:0]   row_q;
	logic                        last_q;
	logic                        done_q;

	logic                        out_free;
	logic                        fire;
	logic                        last_fire;
	logic [cpg_pkg::PIX_W-1:0]   cx;
	logic [cpg_pkg::PIX_W-1:0]   cy;
	logic [cpg_pkg::PIX_W-1:0]   off_a;
	logic [cpg_pkg::PIX_W-1:0]   off_b;
	logic [cpg_pkg::PIX_W-1:0]   pix_col;
	logic [cpg_pkg::PIX_W-1:0]   pix_row;

	assign out_free  = !valid_q || out_ready;
	assign fire      = have_q && out_free;
	assign last_fire = fire && (idx_q == cpg_pkg::PIX_LAST_IDX);
	assign pop       = !q_empty && (!have_q || last_fire);

	always_comb begin
		cx      = {2'b0, center_col & CMASK};
		cy      = {2'b0, center_row & CMASK};
		off_a   = {3'b0, idx_q[2] ? cur_q.y : cur_q.x};
		off_b   = {3'b0, idx_q[2] ? cur_q.x : cur_q.y};
		pix_col = idx_q[0] ? cx - off_a : cx + off_a;
		pix_row = idx_q[1] ? cy + off_b : cy - off_b;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
		if (fire) begin
			col_q  <= pix_col;
			row_q  <= pix_row;
			last_q <= idx_q == cpg_pkg::PIX_LAST_IDX;
			done_q <= cur_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				have_q <= 1'b1;
			end else if (last_fire) begin
				have_q <= 1'b0;
			end
			if (fire) begin
				idx_q <= idx_q + 3'd1;
			end
			if (fire) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_col   = col_q;
	assign out_row   = row_q;
	assign out_last  = last_q;
	assign out_done  = done_q;

`ifndef SYNTHESIS
	a_step_runs_to_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && idx_q != cpg_pkg::PIX_LAST_IDX |=> have_q)
		else $error("step dropped before its eighth pixel");
	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> idx_q == '0)
		else $error("pixel index not at start between steps");
`endif

endmodule

// ===== rtl/circle_point_generator.sv =====
// ----------------------------------------------------------------------------
// circle_point_generator
// Midpoint circle rasterizer: one octant step per transaction, eight pixels.
// ----------------------------------------------------------------------------
// The first pixel of a step passes through the step queue, the step register and the output register.
// Throughput: one pixel per cycle on the output port while m_axis_tready is high;
//   the two-entry step queue takes new transactions while pixels drain.
// An advance transaction with no circle in progress produces no pixels.
// Reset (arst_n low) clears config registers, step state, queue and output.
module circle_point_generator #(
	parameter int COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [cpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cpg_pkg::CENTER_W-1:0]       cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [0] start_req, [7:1] zero
	input  logic [cpg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [13:0] pixel_col, [27:14] pixel_row, [31:28] zero
	output logic [cpg_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                               m_axis_tlast,
	// [0] circle_done
	output logic                               m_axis_tuser
);

	logic [cpg_pkg::CENTER_W-1:0] center_col_q;
	logic [cpg_pkg::CENTER_W-1:0] center_row_q;
	logic [cpg_pkg::RADIUS_W-1:0] radius_q;

	logic                         q_full;
	logic                         q_empty;
	logic                         q_push;
	logic                         q_pop;
	cpg_pkg::step_t               q_wdata;
	cpg_pkg::step_t               q_rdata;
	logic [cpg_pkg::PIX_W-1:0]    pix_col;
	logic [cpg_pkg::PIX_W-1:0]    pix_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			radius_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cpg_pkg::REG_CENTER_COL: center_col_q <= cfg_wdata;
				cpg_pkg::REG_CENTER_ROW: center_row_q <= cfg_wdata;
				cpg_pkg::REG_RADIUS:     radius_q <= cfg_wdata[cpg_pkg::RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	cpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_start  (s_axis_tdata[0]),
		.in_ready  (s_axis_tready),
		.radius    (radius_q),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_wdata)
	);

	cpg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.full      (q_full),
		.empty     (q_empty)
	);

	cpg_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.pop        (q_pop),
		.center_col (center_col_q),
		.center_row (center_row_q),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_col    (pix_col),
		.out_row    (pix_row),
		.out_last   (m_axis_tlast),
		.out_done   (m_axis_tuser)
	);

	assign m_axis_tdata = {4'b0, pix_row, pix_col};

endmodule
